[src/dtc_pkg.sv]
// ----------------------------------------------------------------------------
// dtc_pkg: shared types and constants of the two-level dispatch cache
// Operation, status and register codes, the set index hash and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package dtc_pkg;

   localparam int ADDR_BITS     = 48;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 1;
   localparam int RECENT_ENTRIES = 2;

   localparam int HASH_SHIFT    = 4;
   localparam int HASH_SEL_SHR  = 9;
   localparam int HASH_CLS_SHR  = 11;

   localparam logic [1:0] OP_LOOKUP   = 2'd0;
   localparam logic [1:0] OP_FILL     = 2'd1;
   localparam logic [1:0] OP_CLEAR    = 2'd2;
   localparam logic [1:0] OP_RESERVED = 2'd3;

   localparam logic [2:0] STATUS_L0_HIT     = 3'd0;
   localparam logic [2:0] STATUS_GLOBAL_HIT = 3'd1;
   localparam logic [2:0] STATUS_MISS       = 3'd2;
   localparam logic [2:0] STATUS_NULL_KEY   = 3'd3;
   localparam logic [2:0] STATUS_FILLED     = 3'd4;
   localparam logic [2:0] STATUS_NOT_CACHED = 3'd5;
   localparam logic [2:0] STATUS_CLEARED    = 3'd6;

   localparam logic [CSR_IDX_BITS-1:0] CSR_TWO_WAY  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_L0_DUAL  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_NEG_CACHE = 2'd2;

   typedef struct packed {
      logic load;
      logic exec;
      logic sweep;
   } dtc_cmd_type;

   typedef struct packed {
      logic clear_op;
      logic out_busy;
      logic sweep_last;
   } dtc_stat_type;

   function automatic logic [ADDR_BITS-1:0] set_hash(input logic [ADDR_BITS-1:0] cls,
                                                     input logic [ADDR_BITS-1:0] sel);
      logic [ADDR_BITS-1:0] cb;
      logic [ADDR_BITS-1:0] sb;
      cb = cls >> HASH_SHIFT;
      sb = sel >> HASH_SHIFT;
      return cb ^ sb ^ (sb >> HASH_SEL_SHR) ^ (cb >> HASH_CLS_SHR);
   endfunction

endpackage

[src/dtc_if.sv]
// ----------------------------------------------------------------------------
// dtc_if: request and response channels of the dispatch cache
// Valid and ready handshake with the item payload of each channel.
// ----------------------------------------------------------------------------
interface dtc_req_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   operation;
   logic [dtc_pkg::ADDR_BITS-1:0] class_key;
   logic [dtc_pkg::ADDR_BITS-1:0] selector_key;
   logic [dtc_pkg::ADDR_BITS-1:0] fill_target;
   logic                         fill_found;

   modport source(output valid, operation, class_key, selector_key, fill_target,
                  fill_found, input ready);
   modport sink(input valid, operation, class_key, selector_key, fill_target,
                fill_found, output ready);
endinterface

interface dtc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [2:0]                   status;
   logic [dtc_pkg::ADDR_BITS-1:0] target;
   logic                         target_is_nil;

   modport source(output valid, status, target, target_is_nil, input ready);
   modport sink(input valid, status, target, target_is_nil, output ready);
endinterface

[src/dtc_bank.sv]
// ----------------------------------------------------------------------------
// dtc_bank: one way bank of the global store
// Single write port and one registered read port.
// ----------------------------------------------------------------------------
module dtc_bank #(
   parameter int ROWS  = 128,
   parameter int WIDTH = 146
) (
   input  logic                    clock,
   input  logic                    rd_en,
   input  logic [$clog2(ROWS)-1:0] rd_row,
   input  logic                    wr_en,
   input  logic [$clog2(ROWS)-1:0] wr_row,
   input  logic [WIDTH-1:0]        wr_data,
   output logic [WIDTH-1:0]        rd_data
);

   logic [WIDTH-1:0] mem_ff [ROWS];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_row] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_row];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/dtc_ctrl.sv]
// ----------------------------------------------------------------------------
// dtc_ctrl: sequencer of the dispatch cache
// Steps each item through read and execute, and runs the clearing sweep.
// ----------------------------------------------------------------------------
module dtc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  dtc_pkg::dtc_stat_type stat,
   output dtc_pkg::dtc_cmd_type  cmd
);
   import dtc_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR = 3'b001,
      S_IDLE  = 3'b010,
      S_EXEC  = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.sweep = 1'b1;
            if (stat.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (!stat.out_busy) begin
               cmd.exec = 1'b1;
               state_in = stat.clear_op ? S_CLEAR : S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[src/dtc_datapath.sv]
// ----------------------------------------------------------------------------
// dtc_datapath: lookup, fill and clear datapath of the dispatch cache
// Holds the L0 entries, the registers, the global store banks and the
// result register.
// ----------------------------------------------------------------------------
module dtc_datapath #(
   parameter int CACHE_ENTRIES = 256,
   parameter int KEY_BITS      = 48
) (
   input  logic                               clock,
   input  logic                               reset,
   input  dtc_pkg::dtc_cmd_type               cmd,
   output dtc_pkg::dtc_stat_type              stat,
   input  logic [1:0]                         req_operation,
   input  logic [dtc_pkg::ADDR_BITS-1:0]      req_class_key,
   input  logic [dtc_pkg::ADDR_BITS-1:0]      req_selector_key,
   input  logic [dtc_pkg::ADDR_BITS-1:0]      req_fill_target,
   input  logic                               req_fill_found,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [2:0]                         rsp_status,
   output logic [dtc_pkg::ADDR_BITS-1:0]      rsp_target,
   output logic                               rsp_target_is_nil,
   input  logic                               csr_write_en,
   input  logic [dtc_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [dtc_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import dtc_pkg::*;

   localparam int TAG_W = (KEY_BITS < ADDR_BITS) ? KEY_BITS : ADDR_BITS;
   localparam int ROWS  = CACHE_ENTRIES / 2;
   localparam int ROW_W = $clog2(ROWS);
   localparam int ENT_W = 2 + ADDR_BITS + 2 * TAG_W;

   logic two_way_ff, dual_ff, neg_ff;

   logic [1:0]           op_ff;
   logic [TAG_W-1:0]     cls_ff, sel_ff;
   logic [ADDR_BITS-1:0] fill_t_ff;
   logic                 found_ff;
   logic [ROW_W-1:0]     row_ff;
   logic                 bank_ff;
   logic [ROW_W-1:0]     clr_row_ff;

   logic [RECENT_ENTRIES-1:0] rv_ff, rn_ff;
   logic [TAG_W-1:0]          rc_ff [RECENT_ENTRIES];
   logic [TAG_W-1:0]          rs_ff [RECENT_ENTRIES];
   logic [ADDR_BITS-1:0]      rt_ff [RECENT_ENTRIES];

   logic                 rsp_valid_ff;
   logic [2:0]           rsp_status_ff;
   logic [ADDR_BITS-1:0] rsp_target_ff;
   logic                 rsp_nil_ff;

   logic [TAG_W-1:0]     req_cls, req_sel;
   logic [ADDR_BITS-1:0] req_hash;
   logic [ROW_W-1:0]     rd_row;

   logic [ENT_W-1:0] rd0, rd1;
   logic [ENT_W-1:0] wr0_data, wr1_data, new_ent;
   logic             wr0_en, wr1_en;
   logic [ROW_W-1:0] wr_row;

   logic                 e0_v, e0_n, e1_v, e1_n, ga_v, ga_n;
   logic [ADDR_BITS-1:0] e0_t, e1_t, ga_t;
   logic [TAG_W-1:0]     e0_c, e0_s, e1_c, e1_s, ga_c, ga_s;

   logic gm_a, gm_b, rm0, rm1, l0_hit0, l0_hit1, gh_a, gh_b, null_key;
   logic fnil, fuse;
   logic [ADDR_BITS-1:0] ft;

   logic [2:0]           res_status;
   logic [ADDR_BITS-1:0] res_target;
   logic                 res_nil;
   logic                 rec_we, l0_clear;
   logic [ADDR_BITS-1:0] rec_t;
   logic                 rec_n;

   always_ff @(posedge clock) begin
      if (reset) begin
         two_way_ff <= 1'b1;
         dual_ff    <= 1'b1;
         neg_ff     <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_TWO_WAY:   two_way_ff <= csr_data[0];
            CSR_L0_DUAL:   dual_ff    <= csr_data[0];
            CSR_NEG_CACHE: neg_ff     <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign req_cls  = req_class_key[TAG_W-1:0];
   assign req_sel  = req_selector_key[TAG_W-1:0];
   assign req_hash = set_hash(ADDR_BITS'(req_cls), ADDR_BITS'(req_sel));
   assign rd_row   = two_way_ff ? req_hash[ROW_W-1:0] : req_hash[ROW_W:1];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_operation;
         cls_ff    <= req_cls;
         sel_ff    <= req_sel;
         fill_t_ff <= req_fill_target;
         found_ff  <= req_fill_found;
         row_ff    <= rd_row;
         bank_ff   <= req_hash[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_row_ff <= '0;
      end else if (cmd.sweep) begin
         clr_row_ff <= clr_row_ff + ROW_W'(1);
      end
   end

   assign wr_row = cmd.sweep ? clr_row_ff : row_ff;

   dtc_bank #(.ROWS(ROWS), .WIDTH(ENT_W)) u_bank0 (
      .clock   (clock),
      .rd_en   (cmd.load),
      .rd_row  (rd_row),
      .wr_en   (cmd.sweep | (cmd.exec & wr0_en)),
      .wr_row  (wr_row),
      .wr_data (cmd.sweep ? '0 : wr0_data),
      .rd_data (rd0)
   );

   dtc_bank #(.ROWS(ROWS), .WIDTH(ENT_W)) u_bank1 (
      .clock   (clock),
      .rd_en   (cmd.load),
      .rd_row  (rd_row),
      .wr_en   (cmd.sweep | (cmd.exec & wr1_en)),
      .wr_row  (wr_row),
      .wr_data (cmd.sweep ? '0 : wr1_data),
      .rd_data (rd1)
   );

   assign e0_v = rd0[ENT_W-1];
   assign e0_n = rd0[ENT_W-2];
   assign e0_t = rd0[2*TAG_W +: ADDR_BITS];
   assign e0_s = rd0[TAG_W +: TAG_W];
   assign e0_c = rd0[0 +: TAG_W];
   assign e1_v = rd1[ENT_W-1];
   assign e1_n = rd1[ENT_W-2];
   assign e1_t = rd1[2*TAG_W +: ADDR_BITS];
   assign e1_s = rd1[TAG_W +: TAG_W];
   assign e1_c = rd1[0 +: TAG_W];

   assign ga_v = (!two_way_ff && bank_ff) ? e1_v : e0_v;
   assign ga_n = (!two_way_ff && bank_ff) ? e1_n : e0_n;
   assign ga_t = (!two_way_ff && bank_ff) ? e1_t : e0_t;
   assign ga_c = (!two_way_ff && bank_ff) ? e1_c : e0_c;
   assign ga_s = (!two_way_ff && bank_ff) ? e1_s : e0_s;

   assign gm_a    = ga_v && ga_c == cls_ff && ga_s == sel_ff;
   assign gm_b    = two_way_ff && e1_v && e1_c == cls_ff && e1_s == sel_ff;
   assign rm0     = rv_ff[0] && rc_ff[0] == cls_ff && rs_ff[0] == sel_ff;
   assign rm1     = rv_ff[1] && rc_ff[1] == cls_ff && rs_ff[1] == sel_ff;
   assign l0_hit0 = rm0 && (!rn_ff[0] || neg_ff);
   assign l0_hit1 = dual_ff && rm1 && (!rn_ff[1] || neg_ff);
   assign gh_a    = gm_a && (!ga_n || neg_ff);
   assign gh_b    = gm_b && (!e1_n || neg_ff);
   assign null_key = cls_ff == '0 || sel_ff == '0;

   assign fnil    = !found_ff || fill_t_ff == '0;
   assign ft      = fnil ? '0 : fill_t_ff;
   assign fuse    = !fnil || neg_ff;
   assign new_ent = {1'b1, fnil, ft, sel_ff, cls_ff};

   always_comb begin
      res_status = STATUS_MISS;
      res_target = '0;
      res_nil    = 1'b0;
      rec_we     = 1'b0;
      rec_t      = '0;
      rec_n      = 1'b0;
      l0_clear   = 1'b0;
      wr0_en     = 1'b0;
      wr1_en     = 1'b0;
      wr0_data   = new_ent;
      wr1_data   = new_ent;
      case (op_ff)
         OP_CLEAR: begin
            res_status = STATUS_CLEARED;
            l0_clear   = 1'b1;
         end
         OP_LOOKUP: begin
            if (null_key) begin
               res_status = STATUS_NULL_KEY;
               res_nil    = 1'b1;
            end else if (l0_hit0) begin
               res_status = STATUS_L0_HIT;
               res_target = rt_ff[0];
               res_nil    = rn_ff[0];
            end else if (l0_hit1) begin
               res_status = STATUS_L0_HIT;
               res_target = rt_ff[1];
               res_nil    = rn_ff[1];
            end else if (gh_a) begin
               res_status = STATUS_GLOBAL_HIT;
               res_target = ga_t;
               res_nil    = ga_n;
               rec_we     = 1'b1;
            end else if (gh_b) begin
               res_status = STATUS_GLOBAL_HIT;
               res_target = e1_t;
               res_nil    = e1_n;
               rec_we     = 1'b1;
            end
            rec_t = res_target;
            rec_n = res_nil;
         end
         OP_FILL: begin
            if (null_key) begin
               res_status = STATUS_NULL_KEY;
               res_nil    = 1'b1;
            end else begin
               res_target = ft;
               res_nil    = fnil;
               rec_t      = ft;
               rec_n      = fnil;
               if (fuse) begin
                  res_status = STATUS_FILLED;
                  rec_we     = 1'b1;
                  if (!two_way_ff) begin
                     wr0_en = !bank_ff;
                     wr1_en = bank_ff;
                  end else if (gm_a) begin
                     wr0_en = 1'b1;
                  end else if (gm_b) begin
                     wr1_en = 1'b1;
                  end else if (!e0_v) begin
                     wr0_en = 1'b1;
                  end else if (!e1_v) begin
                     wr1_en = 1'b1;
                  end else begin
                     wr0_en   = 1'b1;
                     wr1_en   = 1'b1;
                     wr1_data = rd0;
                  end
               end else begin
                  res_status = STATUS_NOT_CACHED;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= '0;
      end else if (cmd.exec) begin
         if (l0_clear) begin
            rv_ff <= '0;
         end else if (rec_we) begin
            if (dual_ff && !rm0) begin
               rv_ff[1] <= rv_ff[0];
            end
            rv_ff[0] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && rec_we) begin
         if (dual_ff && !rm0) begin
            rc_ff[1] <= rc_ff[0];
            rs_ff[1] <= rs_ff[0];
            rt_ff[1] <= rt_ff[0];
            rn_ff[1] <= rn_ff[0];
         end
         rc_ff[0] <= cls_ff;
         rs_ff[0] <= sel_ff;
         rt_ff[0] <= rec_t;
         rn_ff[0] <= rec_n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.exec) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_status_ff <= res_status;
         rsp_target_ff <= res_target;
         rsp_nil_ff    <= res_nil;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_target        = rsp_target_ff;
   assign rsp_target_is_nil = rsp_nil_ff;

   assign stat.clear_op   = op_ff == OP_CLEAR;
   assign stat.out_busy   = rsp_valid_ff && !rsp_ready;
   assign stat.sweep_last = &clr_row_ff;

endmodule

[src/two_level_dispatch_cache.sv]
// An accepted item reads its way-bank rows into registers; its result is
// registered in the execute state, which waits while the previous result is
// unaccepted. A new item is accepted only once the previous one has executed.
// A clear item is followed by a sweep of CACHE_ENTRIES/2 rows, one bank row
// per cycle. Reset runs the same sweep, with no item accepted until it ends.
// ----------------------------------------------------------------------------
// two_level_dispatch_cache: method dispatch cache with an L0
// Two-entry recent store in front of a hashed two-way or direct-mapped
// global store; misses are answered by the host with fill items.
// ----------------------------------------------------------------------------
module two_level_dispatch_cache #(
   parameter int CACHE_ENTRIES = 256,
   parameter int KEY_BITS      = 48
) (
   input  logic                              clock,
   input  logic                              reset,
   dtc_req_if.sink                           req_ch,
   dtc_rsp_if.source                         rsp_ch,
   input  logic                              csr_write_en,
   input  logic [dtc_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [dtc_pkg::CSR_DATA_BITS-1:0] csr_data
);
   import dtc_pkg::*;

   dtc_cmd_type  cmd;
   dtc_stat_type stat;

   dtc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dtc_datapath #(
      .CACHE_ENTRIES (CACHE_ENTRIES),
      .KEY_BITS      (KEY_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_operation     (req_ch.operation),
      .req_class_key     (req_ch.class_key),
      .req_selector_key  (req_ch.selector_key),
      .req_fill_target   (req_ch.fill_target),
      .req_fill_found    (req_ch.fill_found),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_status        (rsp_ch.status),
      .rsp_target        (rsp_ch.target),
      .rsp_target_is_nil (rsp_ch.target_is_nil),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

endmodule
